>>> rtl/core/tlsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsp_pkg
// Phase codes, state and result types, and state transition helpers shared
// by the TLS record and handshake parser.
// ----------------------------------------------------------------------------
package tlsp_pkg;

    localparam logic [3:0] PH_RECTYPE  = 4'd0;
    localparam logic [3:0] PH_VERMAJ   = 4'd1;
    localparam logic [3:0] PH_VERMIN   = 4'd2;
    localparam logic [3:0] PH_RECLEN   = 4'd3;
    localparam logic [3:0] PH_HSTYPE   = 4'd4;
    localparam logic [3:0] PH_HSLEN    = 4'd5;
    localparam logic [3:0] PH_LISTLEN  = 4'd6;
    localparam logic [3:0] PH_CERTLEN  = 4'd7;
    localparam logic [3:0] PH_CERTDATA = 4'd8;
    localparam logic [3:0] PH_HSBODY   = 4'd9;
    localparam logic [3:0] PH_PAYLOAD  = 4'd10;
    localparam logic [3:0] PH_RAW      = 4'd11;

    localparam logic [7:0] HANDSHAKE_TYPE   = 8'd22;
    localparam logic [7:0] CERTIFICATE_TYPE = 8'd11;
    localparam logic [7:0] CERT_COUNT_MAX   = 8'd255;

    // header sizes in bytes
    localparam logic [1:0]  RECLEN_BYTES   = 2'd2;
    localparam logic [1:0]  LEN24_BYTES    = 2'd3;
    localparam logic [15:0] HS_HDR_BYTES   = 16'd4;
    localparam logic [23:0] LEN24_HDR_SIZE = 24'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_REC_HDR   = 2'd1;
    localparam logic [1:0] ERR_HS_HDR    = 2'd2;
    localparam logic [1:0] ERR_CERT_DATA = 2'd3;

    localparam int TDATA_W = 56;
    localparam int TUSER_W = 8;

    typedef struct packed {
        logic [3:0]  phase;
        logic [1:0]  field_byte_count;
        logic [23:0] field_shift;
        logic [15:0] record_remaining;
        logic [23:0] message_remaining;
        logic [23:0] cert_list_remaining;
        logic [23:0] cert_remaining;
        logic [7:0]  content_type;
        logic [7:0]  message_type;
        logic [7:0]  cert_count;
    } t_state;

    typedef struct packed {
        logic [3:0]  byte_role;
        logic        field_done;
        logic [23:0] field_value;
        logic [7:0]  content_type;
        logic [7:0]  message_type;
        logic [7:0]  cert_index;
        logic        cert_start;
        logic        cert_end;
        logic [1:0]  error_code;
    } t_result;

    function automatic logic [23:0] f_dec24(logic [23:0] v);
        return (v != 24'd0) ? v - 24'd1 : 24'd0;
    endfunction

    function automatic logic [15:0] f_dec16(logic [15:0] v);
        return (v != 16'd0) ? v - 16'd1 : 16'd0;
    endfunction

    function automatic logic [23:0] f_min24(logic [23:0] a, logic [23:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_state f_go_record(t_state s);
        t_state r;
        r                  = s;
        r.phase            = PH_RECTYPE;
        r.message_type     = 8'd0;
        r.cert_count       = 8'd0;
        r.field_byte_count = 2'd0;
        r.field_shift      = 24'd0;
        return r;
    endfunction

    function automatic t_state f_go_raw(t_state s);
        t_state r;
        r              = s;
        r.phase        = PH_RAW;
        r.message_type = 8'd0;
        r.cert_count   = 8'd0;
        return r;
    endfunction

    function automatic t_state f_start_message(t_state s);
        t_state r;
        r              = s;
        r.message_type = 8'd0;
        r.cert_count   = 8'd0;
        r.phase        = (s.record_remaining >= HS_HDR_BYTES) ? PH_HSTYPE : PH_RAW;
        return r;
    endfunction

    function automatic t_state f_after_list(t_state s);
        t_state r;
        r = s;
        if (s.message_remaining != 24'd0) begin
            r.phase = PH_HSBODY;
        end else begin
            r = f_start_message(s);
        end
        return r;
    endfunction

    function automatic t_state f_next_cert(t_state s);
        t_state r;
        r = s;
        if (s.cert_list_remaining == 24'd0) begin
            r = f_after_list(s);
        end else if (s.cert_list_remaining >= LEN24_HDR_SIZE) begin
            r.phase            = PH_CERTLEN;
            r.field_byte_count = 2'd0;
            r.field_shift      = 24'd0;
            if (s.cert_count < CERT_COUNT_MAX) begin
                r.cert_count = s.cert_count + 8'd1;
            end
        end else begin
            r = f_go_raw(s);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/tlsp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsp_step
// Per-byte parse logic: from the current state and one byte, form the byte's
// result and the next parser state.
// ----------------------------------------------------------------------------
module tlsp_step import tlsp_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_state     o_state,
    output t_result    o_result
);

    t_state      n;
    t_result     res;
    logic [3:0]  role;
    logic        rec_cut;
    logic        hs_cut;
    logic        body;
    logic        took;

    always_comb begin
        n        = i_state;
        role     = (i_state.phase > PH_RAW) ? PH_RAW : i_state.phase;
        rec_cut  = 1'b0;
        hs_cut   = 1'b0;
        body     = 1'b1;
        took     = 1'b0;

        res              = '0;
        res.byte_role    = role;
        res.message_type = i_state.message_type;
        res.cert_index   = (role == PH_CERTLEN || role == PH_CERTDATA) ?
                           i_state.cert_count : 8'd0;

        if (role == PH_RECTYPE) begin
            n.content_type = i_byte;
        end
        res.content_type = n.content_type;

        unique case (role)
            PH_RECTYPE: begin
                res.field_done   = 1'b1;
                res.field_value  = {16'd0, i_byte};
                res.message_type = 8'd0;
                n.phase          = PH_VERMAJ;
                rec_cut          = 1'b1;
                body             = 1'b0;
            end
            PH_VERMAJ: begin
                res.field_done  = 1'b1;
                res.field_value = {16'd0, i_byte};
                n.phase         = PH_VERMIN;
                rec_cut         = 1'b1;
                body            = 1'b0;
            end
            PH_VERMIN: begin
                res.field_done     = 1'b1;
                res.field_value    = {16'd0, i_byte};
                n.phase            = PH_RECLEN;
                n.field_byte_count = 2'd0;
                n.field_shift      = 24'd0;
                rec_cut            = 1'b1;
                body               = 1'b0;
            end
            PH_RECLEN: begin
                body               = 1'b0;
                n.field_shift      = {i_state.field_shift[15:0], i_byte};
                n.field_byte_count = i_state.field_byte_count + 2'd1;
                took               = (n.field_byte_count >= RECLEN_BYTES);
                if (took) begin
                    res.field_done     = 1'b1;
                    res.field_value    = n.field_shift;
                    n.record_remaining = n.field_shift[15:0];
                    n.field_byte_count = 2'd0;
                    n.field_shift      = 24'd0;
                    if (n.record_remaining == 16'd0) begin
                        n = f_go_record(n);
                    end else if (n.content_type == HANDSHAKE_TYPE) begin
                        n = f_start_message(n);
                    end else begin
                        n.phase = PH_PAYLOAD;
                    end
                end else begin
                    rec_cut = 1'b1;
                end
            end
            PH_HSTYPE: begin
                n.record_remaining = f_dec16(i_state.record_remaining);
                n.message_type     = i_byte;
                res.message_type   = i_byte;
                res.field_done     = 1'b1;
                res.field_value    = {16'd0, i_byte};
                n.phase            = PH_HSLEN;
                n.field_byte_count = 2'd0;
                n.field_shift      = 24'd0;
                hs_cut             = 1'b1;
            end
            PH_HSLEN: begin
                n.record_remaining = f_dec16(i_state.record_remaining);
                n.field_shift      = {i_state.field_shift[15:0], i_byte};
                n.field_byte_count = i_state.field_byte_count + 2'd1;
                took               = (n.field_byte_count >= LEN24_BYTES);
                if (took) begin
                    res.field_done      = 1'b1;
                    res.field_value     = n.field_shift;
                    n.field_byte_count  = 2'd0;
                    n.field_shift       = 24'd0;
                    n.message_remaining = f_min24(res.field_value,
                                                  {8'd0, n.record_remaining});
                    if (n.message_type == CERTIFICATE_TYPE) begin
                        if (n.message_remaining >= LEN24_HDR_SIZE) begin
                            n.phase = PH_LISTLEN;
                        end else begin
                            n = f_go_raw(n);
                        end
                    end else begin
                        n = f_after_list(n);
                    end
                end else begin
                    hs_cut = 1'b1;
                end
            end
            PH_LISTLEN: begin
                n.record_remaining  = f_dec16(i_state.record_remaining);
                n.message_remaining = f_dec24(i_state.message_remaining);
                n.field_shift       = {i_state.field_shift[15:0], i_byte};
                n.field_byte_count  = i_state.field_byte_count + 2'd1;
                took                = (n.field_byte_count >= LEN24_BYTES);
                if (took) begin
                    res.field_done        = 1'b1;
                    res.field_value       = n.field_shift;
                    n.field_byte_count    = 2'd0;
                    n.field_shift         = 24'd0;
                    n.cert_list_remaining = f_min24(res.field_value,
                                                    n.message_remaining);
                    n = f_next_cert(n);
                end else begin
                    hs_cut = 1'b1;
                end
            end
            PH_CERTLEN: begin
                n.record_remaining    = f_dec16(i_state.record_remaining);
                n.message_remaining   = f_dec24(i_state.message_remaining);
                n.cert_list_remaining = f_dec24(i_state.cert_list_remaining);
                n.field_shift         = {i_state.field_shift[15:0], i_byte};
                n.field_byte_count    = i_state.field_byte_count + 2'd1;
                took                  = (n.field_byte_count >= LEN24_BYTES);
                if (took) begin
                    res.field_done     = 1'b1;
                    res.field_value    = n.field_shift;
                    n.field_byte_count = 2'd0;
                    n.field_shift      = 24'd0;
                    n.cert_remaining   = f_min24(res.field_value,
                                                 n.cert_list_remaining);
                    if (n.cert_remaining != 24'd0) begin
                        // mark the first data byte still to come
                        n.phase            = PH_CERTDATA;
                        n.field_byte_count = 2'd1;
                    end else begin
                        n = f_next_cert(n);
                    end
                end else begin
                    hs_cut = 1'b1;
                end
            end
            PH_CERTDATA: begin
                n.record_remaining    = f_dec16(i_state.record_remaining);
                n.message_remaining   = f_dec24(i_state.message_remaining);
                n.cert_list_remaining = f_dec24(i_state.cert_list_remaining);
                n.cert_remaining      = f_dec24(i_state.cert_remaining);
                res.cert_start        = (i_state.field_byte_count == 2'd1);
                n.field_byte_count    = 2'd0;
                if (n.cert_remaining == 24'd0) begin
                    res.cert_end = 1'b1;
                    n = f_next_cert(n);
                end
            end
            PH_HSBODY: begin
                n.record_remaining  = f_dec16(i_state.record_remaining);
                n.message_remaining = f_dec24(i_state.message_remaining);
                if (n.message_remaining == 24'd0) begin
                    n = f_start_message(n);
                end
            end
            default: begin
                n.record_remaining = f_dec16(i_state.record_remaining);
            end
        endcase

        if (body && n.record_remaining == 16'd0) begin
            n = f_go_record(n);
        end

        if (i_last) begin
            if (rec_cut) begin
                res.error_code = ERR_REC_HDR;
            end else if (hs_cut || n.phase == PH_LISTLEN || n.phase == PH_CERTLEN) begin
                res.error_code = ERR_HS_HDR;
            end else if (n.phase == PH_CERTDATA) begin
                res.error_code = ERR_CERT_DATA;
            end else begin
                res.error_code = ERR_NONE;
            end
            // frame over: drop all parse state
            n = '0;
        end
    end

    assign o_state  = n;
    assign o_result = res;

endmodule

>>> rtl/core/tls_record_handshake_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_record_handshake_parser_top
// Byte-stream parser for TLS records, handshake messages and certificate
// lists; one result per input byte.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle while the output is not stalled, and
// each gives exactly one result, presented on the master side after it has
// passed the input register and then the result register. The rate is set
// by the combinational per-byte state update between the input register and
// the result register. While a finished result waits to be taken, one more
// byte can still be held in the input register; the input side stalls only
// when both registers are full and the result is not taken. Every parse
// state returns to reset after a byte marked tlast, so each frame is parsed
// independently.
// ----------------------------------------------------------------------------
module tls_record_handshake_parser_top import tlsp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
    input  logic               s_axis_tlast,   // last_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [0] field_done, [24:1] field_value, [32:25] content_type,
    // [40:33] message_type, [48:41] cert_index, [49] cert_start,
    // [50] cert_end, [52:51] error_code, [55:53] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [TUSER_W-1:0] m_axis_tuser    // [3:0] byte_role, [7:4] zero
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;
    logic       advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    tlsp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out.error_code, r_out.cert_end, r_out.cert_start,
                            r_out.cert_index, r_out.message_type, r_out.content_type,
                            r_out.field_value, r_out.field_done};
    assign m_axis_tuser  = {4'd0, r_out.byte_role};

    // a frame-end byte leaves the parser in its reset state
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_state == '0)
        else $error("parser state not cleared after frame end");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase <= PH_RAW)
        else $error("parser phase out of range");

    a_value_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.field_done |-> r_out.field_value == 24'd0)
        else $error("field value without completed field");

    a_cert_mark_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.cert_start || r_out.cert_end)
            |-> r_out.byte_role == PH_CERTDATA)
        else $error("certificate bound outside certificate data");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the TLS record and handshake parser byte by byte. Frames of records,
// handshake messages and certificate lists (often with wrong lengths, cuts and
// stray bytes) are streamed in. Each accepted byte is run through a local
// parser model, and every result transfer is compared with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;
    import tlsp_pkg::*;

    localparam int IDLE_PCT      = 16;
    localparam int RANDOM_BYTES  = 950;
    localparam int CALM_BYTES    = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int SHOWN_FAULTS  = 10;

    localparam logic [7:0] CT_CHANGE_CIPHER = 8'd20;
    localparam logic [7:0] CT_ALERT         = 8'd21;
    localparam logic [7:0] CT_APP_DATA      = 8'd23;
    localparam logic [7:0] TLS_MAJOR        = 8'd3;
    localparam logic [7:0] TLS12_MINOR      = 8'd3;
    localparam logic [7:0] HS_CLIENT_HELLO  = 8'd1;
    localparam logic [7:0] HS_SERVER_HELLO  = 8'd2;
    localparam logic [7:0] HS_SERVER_DONE   = 8'd14;
    localparam logic [7:0] HS_FINISHED      = 8'd20;

    typedef logic [7:0] octets_t [$];

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;   // [7:0] data_byte
    logic                s_axis_tlast;   // last_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;   // [0] done, [24:1] value, [32:25] ctype,
                                         // [40:33] mtype, [48:41] cert_index,
                                         // [49] start, [50] end, [52:51] error
    logic [TUSER_W-1:0]  m_axis_tuser;   // [3:0] byte_role

    bit                  calm = 1'b0;
    int                  fault_count = 0;
    int                  stall_cycles = 0;
    t_result             byte_results_q [$];

    // parser state seen by the prediction
    logic [3:0]  ph;
    logic [1:0]  fld_cnt;
    logic [23:0] fld_acc;
    logic [23:0] rec_left;
    logic [23:0] msg_left;
    logic [23:0] list_left;
    logic [23:0] cert_left;
    logic [7:0]  rec_type;
    logic [7:0]  msg_type;
    logic [7:0]  cert_num;

    tls_record_handshake_parser_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [23:0] count_down(logic [23:0] v);
        return (v != 24'd0) ? v - 24'd1 : 24'd0;
    endfunction

    function automatic logic [23:0] smaller(logic [23:0] a, logic [23:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic void to_record_header();
        ph       = PH_RECTYPE;
        msg_type = 8'd0;
        cert_num = 8'd0;
        fld_cnt  = 2'd0;
        fld_acc  = 24'd0;
    endfunction

    function automatic void to_raw();
        ph       = PH_RAW;
        msg_type = 8'd0;
        cert_num = 8'd0;
    endfunction

    function automatic void open_message();
        msg_type = 8'd0;
        cert_num = 8'd0;
        ph       = (rec_left >= HS_HDR_BYTES) ? PH_HSTYPE : PH_RAW;
    endfunction

    function automatic void close_list();
        if (msg_left != 24'd0) begin
            ph = PH_HSBODY;
        end else begin
            open_message();
        end
    endfunction

    function automatic void next_certificate();
        if (list_left == 24'd0) begin
            close_list();
        end else if (list_left >= LEN24_HDR_SIZE) begin
            ph      = PH_CERTLEN;
            fld_cnt = 2'd0;
            fld_acc = 24'd0;
            if (cert_num != CERT_COUNT_MAX) begin
                cert_num = cert_num + 8'd1;
            end
        end else begin
            to_raw();
        end
    endfunction

    function automatic logic shift_in(logic [7:0] b, logic [1:0] need);
        fld_acc = {fld_acc[15:0], b};
        fld_cnt = fld_cnt + 2'd1;
        return fld_cnt >= need;
    endfunction

    function automatic void reset_parser();
        to_record_header();
        rec_left  = 24'd0;
        msg_left  = 24'd0;
        list_left = 24'd0;
        cert_left = 24'd0;
        rec_type  = 8'd0;
    endfunction

    function automatic t_result parse_byte(logic [7:0] b, logic lst);
        t_result r;
        logic    rec_cut;
        logic    hs_cut;
        logic    body;
        r            = '0;
        rec_cut      = 1'b0;
        hs_cut       = 1'b0;
        body         = 1'b1;
        r.byte_role  = (ph > PH_RAW) ? PH_RAW : ph;
        r.message_type = msg_type;
        if (r.byte_role == PH_CERTLEN || r.byte_role == PH_CERTDATA) begin
            r.cert_index = cert_num;
        end
        if (r.byte_role == PH_RECTYPE) begin
            rec_type = b;
        end
        r.content_type = rec_type;

        case (r.byte_role)
            PH_RECTYPE: begin
                r.field_done   = 1'b1;
                r.field_value  = {16'd0, b};
                r.message_type = 8'd0;
                ph             = PH_VERMAJ;
                rec_cut        = 1'b1;
                body           = 1'b0;
            end
            PH_VERMAJ: begin
                r.field_done  = 1'b1;
                r.field_value = {16'd0, b};
                ph            = PH_VERMIN;
                rec_cut       = 1'b1;
                body          = 1'b0;
            end
            PH_VERMIN: begin
                r.field_done  = 1'b1;
                r.field_value = {16'd0, b};
                ph            = PH_RECLEN;
                fld_cnt       = 2'd0;
                fld_acc       = 24'd0;
                rec_cut       = 1'b1;
                body          = 1'b0;
            end
            PH_RECLEN: begin
                body = 1'b0;
                if (shift_in(b, RECLEN_BYTES)) begin
                    r.field_done  = 1'b1;
                    r.field_value = fld_acc;
                    rec_left      = fld_acc;
                    fld_cnt       = 2'd0;
                    fld_acc       = 24'd0;
                    if (rec_left == 24'd0) begin
                        to_record_header();
                    end else if (rec_type == HANDSHAKE_TYPE) begin
                        open_message();
                    end else begin
                        ph = PH_PAYLOAD;
                    end
                end else begin
                    rec_cut = 1'b1;
                end
            end
            PH_HSTYPE: begin
                rec_left       = count_down(rec_left);
                msg_type       = b;
                r.message_type = b;
                r.field_done   = 1'b1;
                r.field_value  = {16'd0, b};
                ph             = PH_HSLEN;
                fld_cnt        = 2'd0;
                fld_acc        = 24'd0;
                hs_cut         = 1'b1;
            end
            PH_HSLEN: begin
                rec_left = count_down(rec_left);
                if (shift_in(b, LEN24_BYTES)) begin
                    r.field_done  = 1'b1;
                    r.field_value = fld_acc;
                    fld_cnt       = 2'd0;
                    fld_acc       = 24'd0;
                    msg_left      = smaller(r.field_value, rec_left);
                    if (msg_type == CERTIFICATE_TYPE) begin
                        if (msg_left >= LEN24_HDR_SIZE) begin
                            ph = PH_LISTLEN;
                        end else begin
                            to_raw();
                        end
                    end else begin
                        close_list();
                    end
                end else begin
                    hs_cut = 1'b1;
                end
            end
            PH_LISTLEN: begin
                rec_left = count_down(rec_left);
                msg_left = count_down(msg_left);
                if (shift_in(b, LEN24_BYTES)) begin
                    r.field_done  = 1'b1;
                    r.field_value = fld_acc;
                    fld_cnt       = 2'd0;
                    fld_acc       = 24'd0;
                    list_left     = smaller(r.field_value, msg_left);
                    next_certificate();
                end else begin
                    hs_cut = 1'b1;
                end
            end
            PH_CERTLEN: begin
                rec_left  = count_down(rec_left);
                msg_left  = count_down(msg_left);
                list_left = count_down(list_left);
                if (shift_in(b, LEN24_BYTES)) begin
                    r.field_done  = 1'b1;
                    r.field_value = fld_acc;
                    fld_cnt       = 2'd0;
                    fld_acc       = 24'd0;
                    cert_left     = smaller(r.field_value, list_left);
                    if (cert_left != 24'd0) begin
                        ph      = PH_CERTDATA;
                        fld_cnt = 2'd1;   // marks the first data byte
                    end else begin
                        next_certificate();
                    end
                end else begin
                    hs_cut = 1'b1;
                end
            end
            PH_CERTDATA: begin
                rec_left     = count_down(rec_left);
                msg_left     = count_down(msg_left);
                list_left    = count_down(list_left);
                cert_left    = count_down(cert_left);
                r.cert_start = (fld_cnt == 2'd1);
                fld_cnt      = 2'd0;
                if (cert_left == 24'd0) begin
                    r.cert_end = 1'b1;
                    next_certificate();
                end
            end
            PH_HSBODY: begin
                rec_left = count_down(rec_left);
                msg_left = count_down(msg_left);
                if (msg_left == 24'd0) begin
                    open_message();
                end
            end
            default: begin
                rec_left = count_down(rec_left);
            end
        endcase

        if (body && rec_left == 24'd0) begin
            to_record_header();
        end

        if (lst) begin
            if (rec_cut) begin
                r.error_code = ERR_REC_HDR;
            end else if (hs_cut || ph == PH_LISTLEN || ph == PH_CERTLEN) begin
                r.error_code = ERR_HS_HDR;
            end else if (ph == PH_CERTDATA) begin
                r.error_code = ERR_CERT_DATA;
            end else begin
                r.error_code = ERR_NONE;
            end
            reset_parser();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic string show(t_result r);
        return $sformatf("role=%0d done=%0d val=%h ct=%h mt=%h ci=%0d cs=%0d ce=%0d err=%0d",
                         r.byte_role, r.field_done, r.field_value, r.content_type,
                         r.message_type, r.cert_index, r.cert_start, r.cert_end,
                         r.error_code);
    endfunction

    task automatic note_fault(string msg);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.byte_role    = m_axis_tuser[3:0];
            got.field_done   = m_axis_tdata[0];
            got.field_value  = m_axis_tdata[24:1];
            got.content_type = m_axis_tdata[32:25];
            got.message_type = m_axis_tdata[40:33];
            got.cert_index   = m_axis_tdata[48:41];
            got.cert_start   = m_axis_tdata[49];
            got.cert_end     = m_axis_tdata[50];
            got.error_code   = m_axis_tdata[52:51];
            if (byte_results_q.size() == 0) begin
                note_fault({"unexpected result: ", show(got)});
            end else begin
                want = byte_results_q.pop_front();
                if (got !== want) begin
                    note_fault({"mismatch\n  expected ", show(want), "\n  actual   ", show(got)});
                end
            end
        end
    end

    // end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("** tls_record_handshake_parser_top: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        byte_results_q.insert(byte_results_q.size(), parse_byte(b, lst));
        @(negedge i_clk);
    endtask

    task automatic send_frame(input octets_t f);
        for (int i = 0; i < f.size(); i++) begin
            send_byte(f[i], i == f.size() - 1);
        end
    endtask

    function automatic void put_be(ref octets_t q, input int unsigned v, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            q.insert(q.size(), 8'(v >> (8 * i)));
        end
    endfunction

    function automatic void put_random(ref octets_t q, input int unsigned n);
        repeat (n) q.insert(q.size(), 8'($urandom));
    endfunction

    // mostly the true length; now and then the maximum or a wrong small one
    function automatic int unsigned warp_len(int unsigned n, int unsigned full);
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return full;
        if (pick == 1) return $urandom_range(0, n + 4);
        return n;
    endfunction

    function automatic void add_cert_message(ref octets_t q);
        octets_t     lst;
        octets_t     msg;
        int unsigned len;
        repeat ($urandom_range(0, 3)) begin
            len = $urandom_range(0, 6);
            put_be(lst, warp_len(len, 24'hFFFFFF), 3);
            put_random(lst, len);
        end
        put_be(msg, warp_len(lst.size(), 24'hFFFFFF), 3);
        msg = {msg, lst};
        // leave some bytes after the list
        if ($urandom_range(0, 3) == 0) put_random(msg, $urandom_range(1, 3));
        q.insert(q.size(), CERTIFICATE_TYPE);
        put_be(q, warp_len(msg.size(), 24'hFFFFFF), 3);
        q = {q, msg};
    endfunction

    function automatic void add_plain_message(ref octets_t q);
        int unsigned len;
        len = $urandom_range(0, 6);
        case ($urandom_range(0, 4))
            0:       q.insert(q.size(), HS_CLIENT_HELLO);
            1:       q.insert(q.size(), HS_SERVER_HELLO);
            2:       q.insert(q.size(), HS_SERVER_DONE);
            3:       q.insert(q.size(), HS_FINISHED);
            default: q.insert(q.size(), 8'($urandom));
        endcase
        put_be(q, warp_len(len, 24'hFFFFFF), 3);
        put_random(q, len);
    endfunction

    function automatic void add_record(ref octets_t q);
        octets_t    body;
        logic [7:0] kind;
        if ($urandom_range(0, 9) < 6) begin
            kind = HANDSHAKE_TYPE;
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 1) == 0) add_cert_message(body);
                else add_plain_message(body);
            end
            // too few bytes left for another message header
            if ($urandom_range(0, 4) == 0) put_random(body, $urandom_range(1, 3));
        end else begin
            case ($urandom_range(0, 3))
                0:       kind = CT_CHANGE_CIPHER;
                1:       kind = CT_ALERT;
                2:       kind = CT_APP_DATA;
                default: kind = 8'($urandom);
            endcase
            put_random(body, $urandom_range(0, 8));
        end
        q.insert(q.size(), kind);
        q.insert(q.size(), TLS_MAJOR);
        q.insert(q.size(), 8'($urandom_range(0, 4)));
        put_be(q, warp_len(body.size(), 16'hFFFF), 2);
        q = {q, body};
    endfunction

    // empty record, extreme byte values, record header cut on the last byte
    task automatic test_record_framing();
        send_frame({CT_APP_DATA, TLS_MAJOR, TLS12_MINOR, 8'h00, 8'h00, 8'hFF, 8'h00});
    endtask

    // certificate list with an empty and a one-byte certificate, then a
    // record tail too short for a message header
    task automatic test_certificate_walk();
        send_frame({HANDSHAKE_TYPE, TLS_MAJOR, TLS12_MINOR, 8'h00, 8'h0F,
                    CERTIFICATE_TYPE, 8'h00, 8'h00, 8'h0A,
                    8'h00, 8'h00, 8'h07,
                    8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h01, 8'hAB,
                    8'hEE});
    endtask

    task automatic test_random_frames();
        octets_t     frame;
        int unsigned cut;
        int unsigned fed;
        fed = 0;
        while (fed < RANDOM_BYTES) begin
            frame = {};
            calm  = (fed < CALM_BYTES);
            if ($urandom_range(0, 7) == 0) begin
                put_random(frame, $urandom_range(1, 12));
            end else begin
                repeat ($urandom_range(1, 3)) add_record(frame);
                if ($urandom_range(0, 3) == 0) begin
                    cut = $urandom_range(1, frame.size());
                    while (frame.size() > cut) void'(frame.pop_back());
                end
                if ($urandom_range(0, 15) == 0) begin
                    frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
                end
            end
            send_frame(frame);
            fed += frame.size();
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        reset_parser();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_record_framing();
        test_certificate_walk();
        test_random_frames();
        s_axis_tvalid <= 1'b0;

        while (byte_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("** tls_record_handshake_parser_top: PASSED **");
        end else begin
            $display("** tls_record_handshake_parser_top: FAILED **");
        end
        $finish;
    end

endmodule
